FILE: hw/rtl/permutation_unrank_queen_check_core_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the queen check core
// concurrent checks in simulation, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_QUEEN_CHECK_CORE_MACROS_SVH
`define PERMUTATION_UNRANK_QUEEN_CHECK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// holds at every edge outside reset
`define PUQC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define PUQC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PUQC_ASSERT(name, clk, rst, prop, msg)
`define PUQC_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif

`endif

FILE: hw/rtl/puqc_pkg.sv
// ---------------------------------------------------------------------------
// puqc_pkg
// types, sizes and helper functions for the permutation queen check core
// ---------------------------------------------------------------------------
package puqc_pkg;

  localparam int MAX_N      = 8;
  localparam int COL_W      = 3;
  localparam int RANK_W     = 16;
  localparam int SIZE_W     = 4;
  localparam int PLACE_W    = MAX_N * COL_W;
  localparam int NUM_DIV    = MAX_N - 1;
  localparam int BUMP_SPLIT = 4;
  localparam int NUM_STAGES = NUM_DIV + 1 + 2 + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

  typedef logic [COL_W-1:0]      col_t;
  typedef col_t [MAX_N-1:0]      col_vec_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [PLACE_W-1:0]    place_t;

  // factorial digits collected least significant first
  typedef struct packed {
    rank_t    quot;
    col_vec_t dig;
    size_t    size;
    logic     oor;
  } div_stage_t;

  typedef struct packed {
    col_vec_t dig;
    col_vec_t col;
    size_t    size;
    logic     oor;
  } bump_stage_t;

  function automatic size_t eff_size(input size_t bs);
    size_t n;
    n = bs;
    if (n < size_t'(1)) n = size_t'(1);
    if (n > size_t'(MAX_N)) n = size_t'(MAX_N);
    return n;
  endfunction

  function automatic logic [RANK_W:0] fact_of(input size_t n);
    logic [RANK_W:0] f;
    unique case (n)
      size_t'(0): f = (RANK_W+1)'(1);
      size_t'(1): f = (RANK_W+1)'(1);
      size_t'(2): f = (RANK_W+1)'(2);
      size_t'(3): f = (RANK_W+1)'(6);
      size_t'(4): f = (RANK_W+1)'(24);
      size_t'(5): f = (RANK_W+1)'(120);
      size_t'(6): f = (RANK_W+1)'(720);
      size_t'(7): f = (RANK_W+1)'(5040);
      default:    f = (RANK_W+1)'(40320);
    endcase
    return f;
  endfunction

  // one slice of the bump pass, worked in digit order: digit k is raised by
  // every later digit k+j (j in first..last) that lies on the board and is <= it
  function automatic col_vec_t bump_span(input col_vec_t dig, input col_vec_t col,
                                         input size_t size, input int first,
                                         input int last);
    col_vec_t res;
    int       kp;
    res = col;
    for (int k = 0; k < MAX_N; k++) begin
      for (int j = first; j <= last; j++) begin
        kp = k + j;
        if (kp < MAX_N && kp < int'(size)) begin
          if (dig[kp] <= res[k]) res[k] = res[k] + col_t'(1);
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/puqc_in_if.sv
// ---------------------------------------------------------------------------
// puqc_in_if
// rank channel: valid/ready with one permutation rank per transfer
// ---------------------------------------------------------------------------
interface puqc_in_if;
  logic                  valid;
  logic                  ready;
  puqc_pkg::rank_t       perm_rank;

  modport source (output valid, output perm_rank, input ready);
  modport sink   (input valid, input perm_rank, output ready);
endinterface

FILE: hw/rtl/puqc_out_if.sv
// ---------------------------------------------------------------------------
// puqc_out_if
// result channel: valid/ready with placement and flags per transfer
// ---------------------------------------------------------------------------
interface puqc_out_if;
  logic                  valid;
  logic                  ready;
  puqc_pkg::place_t      placement;
  logic                  is_solution;
  logic                  rank_out_of_range;

  modport source (output valid, output placement, output is_solution,
                  output rank_out_of_range, input ready);
  modport sink   (input valid, input placement, input is_solution,
                  input rank_out_of_range, output ready);
endinterface

FILE: hw/rtl/permutation_unrank_queen_check_core.sv
// ---------------------------------------------------------------------------
// permutation_unrank_queen_check_core
// decodes a permutation rank to queen columns and tests the diagonals
// ---------------------------------------------------------------------------
// Takes one rank per clock and returns one result per clock once full and
// the output is not stalled. The pipeline has eleven stages: a range check
// against board_size factorial, seven stages that peel off one factorial
// digit each (dividing by 2..8 with a constant reciprocal multiply and one
// correction), two stages of the digit bump pass and a final stage that
// checks all row pairs for diagonals and packs the columns. Each stage
// holds its item until the next has room, so a stalled output backs up only
// as far as needed and bubbles close up. board_size (reset 8, 0 acts as 1,
// above 8 acts as 8) is for the user to write through cfg_wr_en/cfg_wr_data
// only while no item is in flight; the block does not enforce this.
module permutation_unrank_queen_check_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  puqc_pkg::size_t        cfg_wr_data,
  puqc_in_if.sink                rank_in,
  puqc_out_if.source             result_out
);

`include "permutation_unrank_queen_check_core_macros.svh"

  localparam int LAST  = puqc_pkg::NUM_STAGES - 1;
  localparam int BUMP0 = puqc_pkg::NUM_DIV + 1;
  localparam int BUMP1 = puqc_pkg::NUM_DIV + 2;
  localparam int RW    = puqc_pkg::RANK_W;
  localparam int PW    = 2 * RW + 1;
  localparam int QW    = RW + 4;

  puqc_pkg::size_t         board_size;
  logic [LAST:0]           vld;
  logic [LAST:0]           rdy;
  puqc_pkg::div_stage_t    ds [0:puqc_pkg::NUM_DIV];
  puqc_pkg::bump_stage_t   bs [0:1];
  puqc_pkg::place_t        out_place;
  logic                    out_sol;
  logic                    out_oor;

  puqc_pkg::size_t         in_size;
  puqc_pkg::col_vec_t      bump0_col;
  puqc_pkg::col_vec_t      bump1_col;
  puqc_pkg::place_t        place_next;
  logic                    conflict;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= puqc_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      board_size <= cfg_wr_data;
    end
  end

  // a stage can load when it is empty or its item moves on
  always_comb begin
    rdy[LAST] = !vld[LAST] || result_out.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign rank_in.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= rank_in.valid;
      for (int i = 1; i <= LAST; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: range check
  assign in_size = puqc_pkg::eff_size(board_size);

  always_ff @(posedge clk) begin
    if (rdy[0] && rank_in.valid) begin
      ds[0].quot <= rank_in.perm_rank;
      ds[0].dig  <= '0;
      ds[0].size <= in_size;
      ds[0].oor  <= {1'b0, rank_in.perm_rank} >= puqc_pkg::fact_of(in_size);
    end
  end

  // stages 1..7: digit k is the remainder of division by k+1
  for (genvar k = 1; k <= puqc_pkg::NUM_DIV; k++) begin : g_div
    localparam int unsigned DIV   = k + 1;
    localparam int unsigned RECIP = (1 << RW) / DIV;

    logic [PW-1:0]      prod;
    puqc_pkg::rank_t    qhat;
    logic [QW-1:0]      qd;
    logic [QW-1:0]      rem;
    logic               fix;
    puqc_pkg::col_vec_t dig_next;

    always_comb begin
      prod = PW'(ds[k-1].quot) * PW'(RECIP);
      qhat = prod[2*RW-1:RW];
      qd   = QW'(qhat) * QW'(DIV);
      rem  = QW'(ds[k-1].quot) - qd;
      // estimate is low by at most one
      fix  = rem >= QW'(DIV);
      dig_next    = ds[k-1].dig;
      dig_next[k] = fix ? puqc_pkg::col_t'(rem - QW'(DIV)) : puqc_pkg::col_t'(rem);
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        ds[k].quot <= fix ? qhat + puqc_pkg::rank_t'(1) : qhat;
        ds[k].dig  <= dig_next;
        ds[k].size <= ds[k-1].size;
        ds[k].oor  <= ds[k-1].oor;
      end
    end
  end

  // bump pass in two slices
  assign bump0_col = puqc_pkg::bump_span(ds[puqc_pkg::NUM_DIV].dig,
                                         ds[puqc_pkg::NUM_DIV].dig,
                                         ds[puqc_pkg::NUM_DIV].size,
                                         1, puqc_pkg::BUMP_SPLIT);
  assign bump1_col = puqc_pkg::bump_span(bs[0].dig, bs[0].col, bs[0].size,
                                         puqc_pkg::BUMP_SPLIT + 1, puqc_pkg::MAX_N - 1);

  always_ff @(posedge clk) begin
    if (rdy[BUMP0] && vld[BUMP0-1]) begin
      bs[0].dig  <= ds[puqc_pkg::NUM_DIV].dig;
      bs[0].col  <= bump0_col;
      bs[0].size <= ds[puqc_pkg::NUM_DIV].size;
      bs[0].oor  <= ds[puqc_pkg::NUM_DIV].oor;
    end
    if (rdy[BUMP1] && vld[BUMP1-1]) begin
      bs[1].dig  <= bs[0].dig;
      bs[1].col  <= bump1_col;
      bs[1].size <= bs[0].size;
      bs[1].oor  <= bs[0].oor;
    end
  end

  // diagonal check and packing; columns are held in digit order, row b
  // takes column size-1-b
  always_comb begin
    puqc_pkg::col_t diff;
    puqc_pkg::col_t idx;
    conflict   = 1'b0;
    place_next = '0;
    diff       = '0;
    idx        = '0;
    for (int j = 0; j < puqc_pkg::MAX_N; j++) begin
      for (int kk = j + 1; kk < puqc_pkg::MAX_N; kk++) begin
        if (kk < int'(bs[1].size)) begin
          diff = (bs[1].col[j] > bs[1].col[kk]) ? bs[1].col[j] - bs[1].col[kk]
                                                : bs[1].col[kk] - bs[1].col[j];
          if (diff == puqc_pkg::col_t'(kk - j)) conflict = 1'b1;
        end
      end
    end
    for (int b = 0; b < puqc_pkg::MAX_N; b++) begin
      if (b < int'(bs[1].size)) begin
        idx = puqc_pkg::col_t'(int'(bs[1].size) - 1 - b);
        place_next[b*puqc_pkg::COL_W +: puqc_pkg::COL_W] = bs[1].col[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST] && vld[LAST-1]) begin
      out_place <= bs[1].oor ? '0 : place_next;
      out_sol   <= !bs[1].oor && !conflict;
      out_oor   <= bs[1].oor;
    end
  end

  assign result_out.valid             = vld[LAST];
  assign result_out.placement         = out_place;
  assign result_out.is_solution       = out_sol;
  assign result_out.rank_out_of_range = out_oor;

  `PUQC_ASSERT(a_oor_result_clear, clk, rst, !(vld[LAST] && out_oor) || (out_place == '0 && !out_sol), "out of range result not cleared")
  `PUQC_ASSERT(a_stage0_size_legal, clk, rst, !vld[0] || (ds[0].size >= puqc_pkg::size_t'(1) && ds[0].size <= puqc_pkg::size_t'(puqc_pkg::MAX_N)), "effective size outside board range")
  `PUQC_ASSERT_NEXT(a_input_enters, clk, rst, rank_in.valid && rank_in.ready, vld[0], "accepted rank not captured")
  `PUQC_ASSERT_NEXT(a_last_stage_loads, clk, rst, vld[LAST-1] && rdy[LAST], vld[LAST], "item lost before output register")

endmodule

FILE: dv/queen_result_checker.sv
// ---------------------------------------------------------------------------
// queen_result_checker
// watches the rank and result channels of the queen check core, predicts
// each placement and flag pair from its own copy of board_size, and
// compares every result transfer against the oldest outstanding prediction
// ---------------------------------------------------------------------------
module queen_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  puqc_pkg::size_t  cfg_wr_data,
  puqc_in_if               rank_mon,
  puqc_out_if              result_mon,
  output int               fail_count,
  output int               pending_count,
  output int               checked_count,
  output int               solution_count,
  output int               oor_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import puqc_pkg::*;

  typedef struct packed {
    place_t placement;
    logic   is_solution;
    logic   rank_out_of_range;
  } queen_result_t;

  queen_result_t placements_due[$];
  size_t         board_sz;
  int            errors;
  int            checked;
  int            solutions;
  int            oor_seen;

  initial begin
    errors        = 0;
    checked       = 0;
    solutions     = 0;
    oor_seen      = 0;
    board_sz      = SIZE_RESET;
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    solution_count = 0;
    oor_count     = 0;
  end

  // unrank through factorial digits, bump to distinct columns, test diagonals
  function automatic queen_result_t decode_and_test(input rank_t r_in, input size_t sz);
    queen_result_t res;
    int            n;
    int            fact[MAX_N+1];
    int            col[MAX_N];
    int            rem;
    int            diff;
    bit            ok;
    res = '0;
    n = int'(sz);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    fact[0] = 1;
    for (int b = 1; b <= MAX_N; b++) fact[b] = fact[b-1] * b;
    for (int b = 0; b < MAX_N; b++) col[b] = 0;
    if (int'(r_in) >= fact[n]) begin
      res.rank_out_of_range = 1'b1;
      return res;
    end
    rem = int'(r_in);
    for (int b = 0; b < n; b++) begin
      col[b] = rem / fact[n-1-b];
      rem    = rem % fact[n-1-b];
    end
    for (int b = n - 1; b > 0; b--) begin
      for (int a = b - 1; a >= 0; a--) begin
        if (col[a] <= col[b]) col[b]++;
      end
    end
    ok = 1'b1;
    for (int j = 0; j < n; j++) begin
      for (int k = j + 1; k < n; k++) begin
        diff = (col[j] > col[k]) ? col[j] - col[k] : col[k] - col[j];
        if (diff == k - j) ok = 1'b0;
      end
    end
    for (int j = 0; j < n; j++) res.placement[COL_W*j +: COL_W] = col[j][COL_W-1:0];
    res.is_solution = ok;
    return res;
  endfunction

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : monitor
    queen_result_t due;
    if (rst) begin
      board_sz = SIZE_RESET;
      placements_due.delete();
    end else begin
      if (cfg_wr_en) board_sz = cfg_wr_data;
      if (rank_mon.valid === 1'b1 && rank_mon.ready === 1'b1)
        placements_due.push_back(decode_and_test(rank_mon.perm_rank, board_sz));
      if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
        if (placements_due.size() == 0) begin
          note_failure($sformatf("result with nothing outstanding: placement %06h sol %0b oor %0b",
                                 result_mon.placement, result_mon.is_solution,
                                 result_mon.rank_out_of_range));
        end else begin
          due = placements_due.pop_front();
          checked++;
          if (due.is_solution) solutions++;
          if (due.rank_out_of_range) oor_seen++;
          if (result_mon.placement !== due.placement ||
              result_mon.is_solution !== due.is_solution ||
              result_mon.rank_out_of_range !== due.rank_out_of_range)
            note_failure($sformatf(
              "expected placement %06h sol %0b oor %0b, got placement %06h sol %0b oor %0b",
              due.placement, due.is_solution, due.rank_out_of_range,
              result_mon.placement, result_mon.is_solution, result_mon.rank_out_of_range));
        end
      end
    end
    fail_count     <= errors;
    pending_count  <= placements_due.size();
    checked_count  <= checked;
    solution_count <= solutions;
    oor_count      <= oor_seen;
  end

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives permutation ranks into the queen check core under several board
// sizes and idling patterns; a checker module beside the core does the
// prediction and comparison, this top gives the verdict
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import puqc_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 20;
  localparam int BATCH_ITEMS  = 75;

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  size_t cfg_wr_data;

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  int fail_count;
  int pending_count;
  int checked_count;
  int solution_count;
  int oor_count;

  puqc_in_if  rank_ch ();
  puqc_out_if result_ch ();

  permutation_unrank_queen_check_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rank_in     (rank_ch),
    .result_out  (result_ch)
  );

  queen_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .rank_mon       (rank_ch),
    .result_mon     (result_ch),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .solution_count (solution_count),
    .oor_count      (oor_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    rank_ch.valid     = 1'b0;
    rank_ch.perm_rank = '0;
    result_ch.ready   = 1'b0;
    send_idle_pct     = 31;
    recv_idle_pct     = 51;
    cycle_count       = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid is only lowered when an idle cycle is chosen, never per transfer
  task automatic send_rank(input rank_t r_in);
    if ($urandom_range(99) < send_idle_pct) begin
      rank_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    rank_ch.valid     <= 1'b1;
    rank_ch.perm_rank <= r_in;
    @(posedge clk);
    while (rank_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic drain;
    rank_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input size_t sz);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly in-range ranks so the bump pass and diagonal test get exercised
  task automatic random_batch(input size_t sz);
    int n;
    int fact;
    int pick;
    n = int'(sz);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    fact = 1;
    for (int b = 2; b <= n; b++) fact = fact * b;
    for (int i = 0; i < BATCH_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 70)
        send_rank(rank_t'($urandom_range(fact - 1)));
      else if (pick < 80)
        send_rank(rank_t'(fact - 1 + $urandom_range(1)));
      else
        send_rank(rank_t'($urandom_range(65535)));
    end
  endtask

  initial begin : stimulus
    int    ranks_full[9];
    int    ranks_four[5];
    size_t regime_sizes[3][4];
    ranks_full = '{0, 1, 40319, 40320, 65535, 43690, 21845, 32768, 32767};
    // 10 and 13 decode to the two solutions of the four-queen board
    ranks_four = '{10, 13, 0, 23, 24};
    regime_sizes = '{'{4'd4, 4'd5, 4'd8, 4'd0},
                     '{4'd6, 4'd15, 4'd1, 4'd7},
                     '{4'd2, 4'd3, 4'd9, 4'd8}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset board size first, then size four and the size extremes
    foreach (ranks_full[i]) send_rank(rank_t'(ranks_full[i]));
    write_size(size_t'(4));
    foreach (ranks_four[i]) send_rank(rank_t'(ranks_four[i]));
    write_size(size_t'(1));
    send_rank(rank_t'(0));
    send_rank(rank_t'(1));
    // zero acts as a one-row board
    write_size(size_t'(0));
    send_rank(rank_t'(0));
    send_rank(rank_t'(1));
    // above eight acts as eight
    write_size(size_t'(15));
    send_rank(rank_t'(40319));
    send_rank(rank_t'(40320));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        write_size(regime_sizes[phase][s]);
        random_batch(regime_sizes[phase][s]);
      end
    end

    drain();
    $display("covered %0d result transfers over board sizes 0 to 15 and three idling patterns",
             checked_count);
    $display("of which %0d were solutions and %0d had a rank out of range, %0d mismatches",
             solution_count, oor_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/puqc_pkg.sv
hw/rtl/puqc_in_if.sv
hw/rtl/puqc_out_if.sv
hw/rtl/permutation_unrank_queen_check_core.sv
dv/queen_result_checker.sv
dv/testbench.sv
